// File: rtl/lsdr_pkg.sv
`timescale 1ns / 1ps

package lsdr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DEB_W       = 8;
    localparam int DIV_W       = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIMIT_DEBOUNCE = 3'd0,
        REG_TOUCH_DEBOUNCE = 3'd1,
        REG_RESTART_PERIOD = 3'd2,
        REG_POLL_PERIOD    = 3'd3,
        REG_RESEND_PERIOD  = 3'd4
    } cfg_index_t;

    localparam logic [DEB_W-1:0] LIMIT_DEBOUNCE_RST = 8'd20;
    localparam logic [DEB_W-1:0] TOUCH_DEBOUNCE_RST = 8'd50;
    localparam logic [DIV_W-1:0] RESTART_PERIOD_RST = 16'd60000;
    localparam logic [DIV_W-1:0] POLL_PERIOD_RST    = 16'd50;
    localparam logic [DIV_W-1:0] RESEND_PERIOD_RST  = 16'd5000;

    typedef struct packed {
        logic [DEB_W-1:0] limit_debounce_count;
        logic [DEB_W-1:0] touch_debounce_count;
        logic [DIV_W-1:0] restart_period;
        logic [DIV_W-1:0] poll_period;
        logic [DIV_W-1:0] resend_period;
    } cfg_t;

    typedef struct packed {
        logic fast_tick;
        logic slow_tick;
        logic upper_sensor;
        logic lower_sensor;
        logic touch_sensor;
    } in_item_t;

    typedef struct packed {
        logic upper_reached;
        logic lower_reached;
        logic direction;
        logic stop_pulse;
        logic touch_event;
        logic restart_pulse;
        logic poll_pulse;
        logic resend_pulse;
    } out_item_t;

endpackage

// File: rtl/lsdr_in_if.sv
`timescale 1ns / 1ps

interface lsdr_in_if;
    import lsdr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lsdr_out_if.sv
`timescale 1ns / 1ps

interface lsdr_out_if;
    import lsdr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/limit_switch_debounce_reverser.sv
`timescale 1ns / 1ps

// Path: a transaction accepted into the input register is loaded into the result register when it
// advances, and the consumer takes it from the result register.
// Throughput: one transaction per clock while result.ready does not stall the result register; the
// input and result registers decouple the two channels, and the single-pass update logic between them sets that figure.
// Reset (rst_n, asynchronous, active low) clears all counters, flags and the direction (up),
// empties both registers and loads the configuration registers with their default values.
module limit_switch_debounce_reverser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lsdr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsdr_pkg::CFG_DATA_W-1:0]    cfg_data,
    lsdr_in_if.sink                            sample,
    lsdr_out_if.source                         result
);
    import lsdr_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t res_reg;
    logic      res_valid_reg;
    out_item_t core_res;
    logic      advance;

    // The pending item moves to the result register whenever that register is
    // empty or is being emptied in this cycle. The debouncer state is committed
    // at the same edge, so the next item always sees fully updated state.
    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !item_valid_reg || advance;

    lsdr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsdr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // Input register: the payload needs no reset, only its valid flag.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_reg <= sample.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            item_valid_reg <= sample.valid;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

`ifndef SYNTHESIS
    // A stop always comes with the limit flag that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_res.stop_pulse |-> core_res.upper_reached || core_res.lower_reached)
    else $error("stop pulse without a limit flag");

    // Fast-tick work never happens on an item without a fast tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item_reg.fast_tick |-> !core_res.stop_pulse && !core_res.restart_pulse)
    else $error("fast-tick result on an item without a fast tick");

    // Slow-tick work never happens on an item without a slow tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item_reg.slow_tick
            |-> !core_res.touch_event && !core_res.poll_pulse && !core_res.resend_pulse)
    else $error("slow-tick result on an item without a slow tick");

    // A stalled item stays in the input register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
    else $error("pending item lost or changed while stalled");

    // The result register empties only through a completed transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid_reg) |-> $past(result.ready))
    else $error("result dropped without being taken");
`endif

endmodule

// File: rtl/lsdr_cfg_regs.sv
`timescale 1ns / 1ps

module lsdr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lsdr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsdr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lsdr_pkg::cfg_t                     cfg
);
    import lsdr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes to unused indexes are dropped; narrow registers keep the low bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_LIMIT_DEBOUNCE: cfg_next.limit_debounce_count = cfg_data[DEB_W-1:0];
                REG_TOUCH_DEBOUNCE: cfg_next.touch_debounce_count = cfg_data[DEB_W-1:0];
                REG_RESTART_PERIOD: cfg_next.restart_period       = cfg_data[DIV_W-1:0];
                REG_POLL_PERIOD:    cfg_next.poll_period          = cfg_data[DIV_W-1:0];
                REG_RESEND_PERIOD:  cfg_next.resend_period        = cfg_data[DIV_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_debounce_count <= LIMIT_DEBOUNCE_RST;
            cfg_reg.touch_debounce_count <= TOUCH_DEBOUNCE_RST;
            cfg_reg.restart_period       <= RESTART_PERIOD_RST;
            cfg_reg.poll_period          <= POLL_PERIOD_RST;
            cfg_reg.resend_period        <= RESEND_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lsdr_core.sv
`timescale 1ns / 1ps

module lsdr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  lsdr_pkg::in_item_t    item,
    input  lsdr_pkg::cfg_t        cfg,
    output lsdr_pkg::out_item_t   res
);
    import lsdr_pkg::*;

    logic             upper_prev_reg, upper_prev_next;
    logic             lower_prev_reg, lower_prev_next;
    logic [DEB_W-1:0] upper_count_reg, upper_count_next;
    logic [DEB_W-1:0] lower_count_reg, lower_count_next;
    logic             upper_flag_reg, upper_flag_next;
    logic             lower_flag_reg, lower_flag_next;
    logic             dir_reg, dir_next;
    logic             touch_prev_reg, touch_prev_next;
    logic [DEB_W-1:0] touch_count_reg, touch_count_next;
    logic             touch_latched_reg, touch_latched_next;
    logic [DIV_W-1:0] restart_count_reg, restart_count_next;
    logic [DIV_W-1:0] poll_count_reg, poll_count_next;
    logic [DIV_W-1:0] resend_count_reg, resend_count_next;

    // Increments are one bit wider so that a limit at full scale is still exceeded.
    logic [DEB_W:0] upper_inc, lower_inc, touch_inc;
    logic [DIV_W:0] restart_inc, poll_inc, resend_inc;
    logic           upper_wrap, lower_wrap, touch_wrap;
    logic           restart_wrap, poll_wrap, resend_wrap;

    assign upper_inc    = {1'b0, upper_count_reg} + {{DEB_W{1'b0}}, 1'b1};
    assign lower_inc    = {1'b0, lower_count_reg} + {{DEB_W{1'b0}}, 1'b1};
    assign touch_inc    = {1'b0, touch_count_reg} + {{DEB_W{1'b0}}, 1'b1};
    assign restart_inc  = {1'b0, restart_count_reg} + {{DIV_W{1'b0}}, 1'b1};
    assign poll_inc     = {1'b0, poll_count_reg} + {{DIV_W{1'b0}}, 1'b1};
    assign resend_inc   = {1'b0, resend_count_reg} + {{DIV_W{1'b0}}, 1'b1};

    assign upper_wrap   = upper_inc > {1'b0, cfg.limit_debounce_count};
    assign lower_wrap   = lower_inc > {1'b0, cfg.limit_debounce_count};
    assign touch_wrap   = touch_inc > {1'b0, cfg.touch_debounce_count};
    assign restart_wrap = restart_inc > {1'b0, cfg.restart_period};
    assign poll_wrap    = poll_inc > {1'b0, cfg.poll_period};
    assign resend_wrap  = resend_inc > {1'b0, cfg.resend_period};

    always_comb
    begin
        upper_prev_next    = upper_prev_reg;
        lower_prev_next    = lower_prev_reg;
        upper_count_next   = upper_count_reg;
        lower_count_next   = lower_count_reg;
        upper_flag_next    = upper_flag_reg;
        lower_flag_next    = lower_flag_reg;
        dir_next           = dir_reg;
        touch_prev_next    = touch_prev_reg;
        touch_count_next   = touch_count_reg;
        touch_latched_next = touch_latched_reg;
        restart_count_next = restart_count_reg;
        poll_count_next    = poll_count_reg;
        resend_count_next  = resend_count_reg;
        res                = '0;

        if (item.fast_tick)
        begin
            // The upper limit goes first; the lower limit sees its direction.
            if (item.upper_sensor && upper_prev_reg)
            begin
                if (upper_wrap)
                begin
                    upper_flag_next  = 1'b1;
                    upper_count_next = '0;
                    if (!dir_next)
                    begin
                        dir_next       = 1'b1;
                        res.stop_pulse = 1'b1;
                    end
                end
                else
                begin
                    upper_count_next = upper_inc[DEB_W-1:0];
                end
            end
            else
            begin
                upper_flag_next  = 1'b0;
                upper_count_next = '0;
            end
            upper_prev_next = item.upper_sensor;

            if (item.lower_sensor && lower_prev_reg)
            begin
                if (lower_wrap)
                begin
                    lower_flag_next  = 1'b1;
                    lower_count_next = '0;
                    if (dir_next)
                    begin
                        dir_next       = 1'b0;
                        res.stop_pulse = 1'b1;
                    end
                end
                else
                begin
                    lower_count_next = lower_inc[DEB_W-1:0];
                end
            end
            else
            begin
                lower_flag_next  = 1'b0;
                lower_count_next = '0;
            end
            lower_prev_next = item.lower_sensor;

            if (restart_wrap)
            begin
                restart_count_next = '0;
                res.restart_pulse  = 1'b1;
            end
            else
            begin
                restart_count_next = restart_inc[DIV_W-1:0];
            end
        end

        if (item.slow_tick)
        begin
            // Touched is low; once latched the count holds until release.
            if (!item.touch_sensor && !touch_prev_reg)
            begin
                if (!touch_latched_reg)
                begin
                    if (touch_wrap)
                    begin
                        touch_count_next   = '0;
                        touch_latched_next = 1'b1;
                        res.touch_event    = 1'b1;
                    end
                    else
                    begin
                        touch_count_next = touch_inc[DEB_W-1:0];
                    end
                end
            end
            else
            begin
                touch_latched_next = 1'b0;
                touch_count_next   = '0;
            end
            touch_prev_next = item.touch_sensor;

            if (poll_wrap)
            begin
                poll_count_next = '0;
                res.poll_pulse  = 1'b1;
            end
            else
            begin
                poll_count_next = poll_inc[DIV_W-1:0];
            end

            if (resend_wrap)
            begin
                resend_count_next = '0;
                res.resend_pulse  = 1'b1;
            end
            else
            begin
                resend_count_next = resend_inc[DIV_W-1:0];
            end
        end

        res.upper_reached = upper_flag_next;
        res.lower_reached = lower_flag_next;
        res.direction     = dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_prev_reg    <= 1'b0;
            lower_prev_reg    <= 1'b0;
            upper_count_reg   <= '0;
            lower_count_reg   <= '0;
            upper_flag_reg    <= 1'b0;
            lower_flag_reg    <= 1'b0;
            dir_reg           <= 1'b0;
            touch_prev_reg    <= 1'b0;
            touch_count_reg   <= '0;
            touch_latched_reg <= 1'b0;
            restart_count_reg <= '0;
            poll_count_reg    <= '0;
            resend_count_reg  <= '0;
        end
        else if (advance)
        begin
            upper_prev_reg    <= upper_prev_next;
            lower_prev_reg    <= lower_prev_next;
            upper_count_reg   <= upper_count_next;
            lower_count_reg   <= lower_count_next;
            upper_flag_reg    <= upper_flag_next;
            lower_flag_reg    <= lower_flag_next;
            dir_reg           <= dir_next;
            touch_prev_reg    <= touch_prev_next;
            touch_count_reg   <= touch_count_next;
            touch_latched_reg <= touch_latched_next;
            restart_count_reg <= restart_count_next;
            poll_count_reg    <= poll_count_next;
            resend_count_reg  <= resend_count_next;
        end
    end

endmodule
